/* design/rd64_pkg.sv */
// ----------------------------------------------------------------------------
// rd64_pkg
// Shared constants and controller/datapath handshake types for the
// radix-2 restoring divider.
// ----------------------------------------------------------------------------
package rd64_pkg;

  // Port width of every operand and result field
  localparam int unsigned RD64_PORT_W    = 64;
  // Default arithmetic width (low bits of each operand that take part)
  localparam int unsigned RD64_WIDTH_DEF = 64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture operands of an accepted beat
    logic prep;    // take magnitudes, latch signs and zero-divisor flag
    logic step;    // one restoring iteration
    logic finish;  // apply sign fix-up and write the output register
  } rd64_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_zero;  // captured divisor is zero (valid during prep)
    logic out_free;  // output register can take a result this cycle
  } rd64_stat_t;

endpackage

/* design/rd64_in_if.sv */
// ----------------------------------------------------------------------------
// rd64_in_if
// Operand channel: dividend, divisor and signed selector with valid/ready.
// ----------------------------------------------------------------------------
interface rd64_in_if
  import rd64_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [RD64_PORT_W-1:0] dividend;
  logic [RD64_PORT_W-1:0] divisor;
  logic                   action;

  modport source (output valid, dividend, divisor, action, input ready);
  modport sink   (input valid, dividend, divisor, action, output ready);
endinterface

/* design/rd64_out_if.sv */
// ----------------------------------------------------------------------------
// rd64_out_if
// Result channel: quotient, remainder and zero-divisor flag with valid/ready.
// ----------------------------------------------------------------------------
interface rd64_out_if
  import rd64_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [RD64_PORT_W-1:0] quotient;
  logic [RD64_PORT_W-1:0] remainder;
  logic                   div_by_zero;

  modport source (output valid, quotient, remainder, div_by_zero, input ready);
  modport sink   (input valid, quotient, remainder, div_by_zero, output ready);
endinterface

/* design/restoring_divider_64.sv */
// ----------------------------------------------------------------------------
// restoring_divider_64
// Radix-2 restoring divider, signed or unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake             beat contents
//   in_ch     in    valid / ready         dividend, divisor, action
//   out_ch    out   valid / ready         quotient, remainder, div_by_zero
//
// An operand beat is taken only while the sequencer is idle. After the
// accepting edge the sequencer steps through prep (take magnitudes and check
// for a zero divisor), the shift-and-subtract iterations (one quotient bit
// each, shared subtractor) and the sign fix-up into the output register. The
// next operand beat is taken only once the fix-up has written the result. A
// zero divisor skips the iterations and goes from prep straight to fix-up.
// Synchronous active-low reset clears the sequencer and the output valid.
// A stalled result sits in the output register while the next operand beat
// is accepted and divided; only the final write waits for it to drain.
//
module restoring_divider_64
  import rd64_pkg::*;
#(
  parameter int unsigned WIDTH = RD64_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rd64_in_if.sink   in_ch,
  rd64_out_if.source out_ch
);

  rd64_cmd_t  cmd;   // sequencer commands to the datapath
  rd64_stat_t stat;  // datapath status back to the sequencer

  // Sequencer: owns input ready and the iteration count
  rd64_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: operands, step unit, fix-up and output register
  rd64_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_dividend     (in_ch.dividend),
    .in_divisor      (in_ch.divisor),
    .in_action       (in_ch.action),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_quotient    (out_ch.quotient),
    .out_remainder   (out_ch.remainder),
    .out_div_by_zero (out_ch.div_by_zero)
  );

endmodule

/* design/rd64_ctrl.sv */
// ----------------------------------------------------------------------------
// rd64_ctrl
// Sequencer: accept, prepare, iterate WIDTH times, fix up and hand off.
// ----------------------------------------------------------------------------
module rd64_ctrl
  import rd64_pkg::*;
#(
  parameter int unsigned WIDTH = RD64_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rd64_stat_t stat,
  output rd64_cmd_t  cmd
);

  localparam int unsigned CW = $clog2(WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIX
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt  = CW'(WIDTH - 1);
        // zero divisor skips the iterations entirely
        state_nxt = stat.div_zero ? ST_FIX : ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        // hold until the output register is free
        cmd.finish = stat.out_free;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* design/rd64_dp.sv */
// ----------------------------------------------------------------------------
// rd64_dp
// Datapath: operand registers, shared shift/subtract step, sign fix-up and
// output register.
// ----------------------------------------------------------------------------
module rd64_dp
  import rd64_pkg::*;
#(
  parameter int unsigned WIDTH = RD64_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rd64_cmd_t              cmd,
  output rd64_stat_t             stat,
  input  logic [RD64_PORT_W-1:0] in_dividend,
  input  logic [RD64_PORT_W-1:0] in_divisor,
  input  logic                   in_action,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RD64_PORT_W-1:0] out_quotient,
  output logic [RD64_PORT_W-1:0] out_remainder,
  output logic                   out_div_by_zero
);

  // nq_r holds the dividend bits still to shift in; quotient bits fill from
  // the bottom as they are produced
  logic [WIDTH-1:0] nq_r;
  logic [WIDTH-1:0] d_r;
  logic [WIDTH-1:0] rem_r;
  logic             sgn_r;
  logic             n_neg_r;
  logic             q_neg_r;
  logic             dz_r;

  logic [RD64_PORT_W-1:0] q_out_r;
  logic [RD64_PORT_W-1:0] r_out_r;
  logic                   dz_out_r;
  logic                   out_valid_r;

  logic [WIDTH-1:0] r_sh;
  logic [WIDTH:0]   diff;
  logic             take;
  logic             n_neg;
  logic             d_neg;
  logic [WIDTH-1:0] q_fix;
  logic [WIDTH-1:0] r_fix;

  // one restoring step; the bit shifted out of the top forces a subtract
  always_comb begin
    r_sh = {rem_r[WIDTH-2:0], nq_r[WIDTH-1]};
    diff = {1'b0, r_sh} - {1'b0, d_r};
    take = rem_r[WIDTH-1] | ~diff[WIDTH];
  end

  assign n_neg = sgn_r & nq_r[WIDTH-1];
  assign d_neg = sgn_r & d_r[WIDTH-1];
  assign q_fix = q_neg_r ? (WIDTH'(0) - nq_r)  : nq_r;
  assign r_fix = n_neg_r ? (WIDTH'(0) - rem_r) : rem_r;

  assign stat.div_zero = (d_r == '0);
  assign stat.out_free = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nq_r  <= in_dividend[WIDTH-1:0];
      d_r   <= in_divisor[WIDTH-1:0];
      sgn_r <= in_action;
    end
    if (cmd.prep) begin
      nq_r    <= n_neg ? (WIDTH'(0) - nq_r) : nq_r;
      d_r     <= d_neg ? (WIDTH'(0) - d_r)  : d_r;
      rem_r   <= '0;
      n_neg_r <= n_neg;
      q_neg_r <= n_neg ^ d_neg;
      dz_r    <= (d_r == '0);
    end
    if (cmd.step) begin
      rem_r <= take ? diff[WIDTH-1:0] : r_sh;
      nq_r  <= {nq_r[WIDTH-2:0], take};
    end
    if (cmd.finish) begin
      q_out_r  <= dz_r ? '0 : RD64_PORT_W'(q_fix);
      r_out_r  <= dz_r ? '0 : RD64_PORT_W'(r_fix);
      dz_out_r <= dz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_quotient    = q_out_r;
  assign out_remainder   = r_out_r;
  assign out_div_by_zero = dz_out_r;

endmodule
